@@ design/index_free_list_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Index free-list allocator: assertion macros
// Concurrent assertion helpers for the allocator back end.
// ----------------------------------------------------------------------------
`ifndef INDEX_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define INDEX_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define IFLA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define IFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator sequence check failed");
`else
`define IFLA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/ifla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Index free-list allocator package
// Widths, result codes, command codes and the types shared by the modules.
// ----------------------------------------------------------------------------
package ifla_pkg;

    localparam int POOL_SIZE_DEF = 1024;
    localparam int SLOT_W        = 10;
    localparam int COUNT_OUT_W   = 11;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    typedef logic [1:0] t_op;
    localparam t_op OP_ALLOC  = 2'd0;
    localparam t_op OP_FREE   = 2'd1;
    localparam t_op OP_REJECT = 2'd2;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic init_done;
    } t_back_status;

endpackage
`default_nettype wire

@@ design/ifla_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts request transactions, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module ifla_front #(
    parameter int POOL_SIZE = ifla_pkg::POOL_SIZE_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire [ifla_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [9:0] slot_to_free
    input  wire                            i_s_tuser,   // [0] action
    input  wire ifla_pkg::t_back_status    i_back_status,
    output logic                           o_push_valid,
    output ifla_pkg::t_cmd                 o_push_cmd,
    input  wire                            i_push_ready
);

    logic            r_valid;
    logic            n_valid;
    ifla_pkg::t_cmd  r_cmd;
    ifla_pkg::t_cmd  n_cmd;
    logic            accept;
    logic [ifla_pkg::SLOT_W-1:0] slot;

    assign slot       = i_s_tdata[ifla_pkg::SLOT_W-1:0];
    assign o_s_tready = i_back_status.init_done && (!r_valid || i_push_ready);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid  = 1'b1;
            n_cmd.slot = slot;
            if (!i_s_tuser) begin
                n_cmd.op = ifla_pkg::OP_ALLOC;
            end else if (32'(slot) >= 32'(POOL_SIZE)) begin
                n_cmd.op = ifla_pkg::OP_REJECT;
            end else begin
                n_cmd.op = ifla_pkg::OP_FREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule
`default_nettype wire

@@ design/ifla_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator command queue
// Two-entry queue that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
module ifla_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    input  wire ifla_pkg::t_cmd  i_push_cmd,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output ifla_pkg::t_cmd       o_pop_cmd,
    input  wire                  i_pop
);

    ifla_pkg::t_cmd r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ design/ifla_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "index_free_list_allocator_core_defines.svh"
// ----------------------------------------------------------------------------
// Allocator back end
// Owns the link memory, the free-list head and the in-use count, runs the
// clearing pass after reset and drives the result register.
// ----------------------------------------------------------------------------
module ifla_back #(
    parameter int POOL_SIZE = ifla_pkg::POOL_SIZE_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_q_valid,
    input  wire ifla_pkg::t_cmd            i_q_cmd,
    output logic                           o_q_pop,
    output ifla_pkg::t_back_status         o_status,
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [ifla_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [ifla_pkg::STATUS_W-1:0]  o_m_tuser
);

    localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(POOL_SIZE - 1);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [LINK_W-1:0] r_link_mem [POOL_SIZE];

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [IDX_W-1:0]  r_clr;
    logic [IDX_W-1:0]  n_clr;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] n_head;
    logic [LINK_W-1:0] r_count;
    logic [LINK_W-1:0] n_count;
    logic [LINK_W-1:0] r_rd_data;

    logic                               r_out_valid;
    logic                               n_out_valid;
    ifla_pkg::t_status                  r_out_status;
    ifla_pkg::t_status                  n_out_status;
    logic [ifla_pkg::SLOT_W-1:0]        r_out_slot;
    logic [ifla_pkg::SLOT_W-1:0]        n_out_slot;
    logic [ifla_pkg::COUNT_OUT_W-1:0]   r_out_count;
    logic [ifla_pkg::COUNT_OUT_W-1:0]   n_out_count;

    logic              out_free;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic              mem_re;
    logic [LINK_W-1:0] dec_count;
    logic [LINK_W-1:0] inc_count;
    logic [LINK_W-1:0] popped_head;

    assign out_free    = !r_out_valid || i_m_tready;
    assign dec_count   = (r_count != '0) ? r_count - LINK_W'(1) : r_count;
    assign inc_count   = (r_count < END_MARK) ? r_count + LINK_W'(1) : r_count;
    // A link that points past the pool ends the list.
    assign popped_head = (r_rd_data > END_MARK) ? END_MARK : r_rd_data;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_head       = r_head;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_clr;
        mem_wdata    = LINK_W'(r_clr) + LINK_W'(1);
        mem_re       = 1'b0;
        o_q_pop      = 1'b0;
        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                n_clr  = r_clr + IDX_W'(1);
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop      = 1'b1;
                    n_out_slot   = '0;
                    n_out_count  = ifla_pkg::COUNT_OUT_W'(r_count);
                    n_out_status = ifla_pkg::ST_OK;
                    case (i_q_cmd.op)
                        ifla_pkg::OP_ALLOC: begin
                            if (r_head == END_MARK) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ifla_pkg::ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_RD;
                            end
                        end
                        ifla_pkg::OP_FREE: begin
                            mem_we      = 1'b1;
                            mem_waddr   = IDX_W'(i_q_cmd.slot);
                            mem_wdata   = r_head;
                            n_head      = LINK_W'(i_q_cmd.slot);
                            n_count     = dec_count;
                            n_out_valid = 1'b1;
                            n_out_count = ifla_pkg::COUNT_OUT_W'(dec_count);
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_status = ifla_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_head       = popped_head;
                n_count      = inc_count;
                n_out_valid  = 1'b1;
                n_out_status = ifla_pkg::ST_OK;
                n_out_slot   = ifla_pkg::SLOT_W'(r_head);
                n_out_count  = ifla_pkg::COUNT_OUT_W'(inc_count);
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_link_mem[IDX_W'(r_head)];
        end
    end

    assign o_status.init_done = (r_state != S_INIT);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_slot};

    `IFLA_ASSERT_IMPLY(a_rd_out_empty, i_clk, i_rst_n, r_state == S_RD, !r_out_valid)
    `IFLA_ASSERT_NEXT(a_rd_one_cycle, i_clk, i_rst_n, r_state == S_RD, r_state == S_IDLE)
    `IFLA_ASSERT_IMPLY(a_head_bound, i_clk, i_rst_n, 1'b1, r_head <= END_MARK)
    `IFLA_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= END_MARK)
    `IFLA_ASSERT_IMPLY(a_init_quiet, i_clk, i_rst_n, r_state == S_INIT,
                       !r_out_valid && !o_q_pop)

endmodule
`default_nettype wire

@@ design/index_free_list_allocator_core.sv @@
// A request passes the front-end register and the queue; a free, a reject or
// an allocate on an empty list then sets the output register, and any other
// allocate first reads its head link; results wait in the output register.
// One free or reject per cycle unless the output stalls; an allocate delays the
// next request until its result is set. Reset: synchronous active low; a
// clearing pass rebuilds the link memory; no request is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Index free-list allocator core
// Hands out and takes back slot indices from a fixed pool kept as a singly
// linked free list in an on-chip link memory.
// ----------------------------------------------------------------------------
module index_free_list_allocator_core #(
    parameter int POOL_SIZE = ifla_pkg::POOL_SIZE_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire [ifla_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [9:0] slot_to_free
    input  wire                            i_s_tuser,   // [0] action
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [ifla_pkg::M_TDATA_W-1:0] o_m_tdata,   // [9:0] granted_slot,
                                                        // [20:10] in_use_count
    output logic [ifla_pkg::STATUS_W-1:0]  o_m_tuser    // [1:0] status
);

    ifla_pkg::t_back_status back_status;
    logic                   push_valid;
    ifla_pkg::t_cmd         push_cmd;
    logic                   push_ready;
    logic                   pop_valid;
    ifla_pkg::t_cmd         pop_cmd;
    logic                   pop;

    ifla_front #(
        .POOL_SIZE (POOL_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_back_status (back_status),
        .o_push_valid  (push_valid),
        .o_push_cmd    (push_cmd),
        .i_push_ready  (push_ready)
    );

    ifla_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    ifla_back #(
        .POOL_SIZE (POOL_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (pop_valid),
        .i_q_cmd    (pop_cmd),
        .o_q_pop    (pop),
        .o_status   (back_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire
